>>> rtl/mws_pkg.sv
// shared types, codes and helper functions of the motor waggle sequencer
package mws_pkg;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [1:0] PH_BEGIN = 2'd0;
    localparam logic [1:0] PH_OSC   = 2'd1;
    localparam logic [1:0] PH_DELAY = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam int UPC_W = 4;

    localparam logic [UPC_W-1:0] UPC_TICK   = 4'd0;
    localparam logic [UPC_W-1:0] UPC_STOP   = 4'd1;
    localparam logic [UPC_W-1:0] UPC_NOP    = 4'd2;
    localparam logic [UPC_W-1:0] UPC_LOAD   = 4'd3;
    localparam logic [UPC_W-1:0] UPC_PQ     = 4'd4;
    localparam logic [UPC_W-1:0] UPC_PHALF  = 4'd5;
    localparam logic [UPC_W-1:0] UPC_WAIT   = 4'd6;
    localparam logic [UPC_W-1:0] UPC_LREM   = 4'd7;
    localparam logic [UPC_W-1:0] UPC_LQ     = 4'd8;
    localparam logic [UPC_W-1:0] UPC_LLAST  = 4'd9;
    localparam logic [UPC_W-1:0] UPC_DQ     = 4'd10;
    localparam logic [UPC_W-1:0] UPC_DPAUSE = 4'd11;

    localparam logic [1:0] X_HOLD    = 2'd0;
    localparam logic [1:0] X_PERIOD  = 2'd1;
    localparam logic [1:0] X_HALFREM = 2'd2;
    localparam logic [1:0] X_DELAY   = 2'd3;

    localparam logic [1:0] DST_NONE  = 2'd0;
    localparam logic [1:0] DST_HALF  = 2'd1;
    localparam logic [1:0] DST_LAST  = 2'd2;
    localparam logic [1:0] DST_PAUSE = 2'd3;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_LOAD = 3'd1;
    localparam logic [2:0] ACT_TICK = 3'd2;
    localparam logic [2:0] ACT_STOP = 3'd3;
    localparam logic [2:0] ACT_ARM  = 3'd4;

    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = 10;

    typedef struct packed {
        logic [1:0] xsel;
        logic       mq;
        logic [1:0] dst;
        logic       div_go;
        logic       wait_div;
        logic [2:0] act;
        logic       fin;
    } ctrl_t;

    typedef struct packed {
        logic        fwd;
        logic [12:0] pulse;
    } motor_t;

    // floor(x / 255) for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

    function automatic motor_t drive_motor(input logic neg, input logic [6:0] mag,
                                           input logic [15:0] pwm);
        logic [12:0] m40;
        logic [16:0] diff;
        motor_t      r;
        m40  = 13'(mag) * 13'd40;
        diff = {1'b0, pwm} - {4'd0, m40};
        if (mag == 7'd0)
        begin
            r.fwd   = 1'b1;
            r.pulse = pwm[12:0];
        end
        else if (!neg)
        begin
            r.fwd   = 1'b1;
            r.pulse = diff[16] ? 13'd0 : diff[12:0];
        end
        else
        begin
            r.fwd   = 1'b0;
            r.pulse = m40;
        end
        return r;
    endfunction

endpackage

>>> rtl/mws_ucode_rom.sv
// control store of the sequencer: one control word per program step
module mws_ucode_rom (
    input  logic [mws_pkg::UPC_W-1:0] upc,
    output mws_pkg::ctrl_t            cw
);

    always_comb
    begin
        cw = '0;
        unique case (upc)
            mws_pkg::UPC_TICK:
            begin
                cw.act = mws_pkg::ACT_TICK;
                cw.fin = 1'b1;
            end
            mws_pkg::UPC_STOP:
            begin
                cw.act = mws_pkg::ACT_STOP;
                cw.fin = 1'b1;
            end
            mws_pkg::UPC_NOP:
            begin
                cw.fin = 1'b1;
            end
            mws_pkg::UPC_LOAD:
            begin
                cw.act  = mws_pkg::ACT_LOAD;
                cw.xsel = mws_pkg::X_PERIOD;
            end
            mws_pkg::UPC_PQ:
            begin
                cw.mq = 1'b1;
            end
            mws_pkg::UPC_PHALF:
            begin
                cw.dst    = mws_pkg::DST_HALF;
                cw.div_go = 1'b1;
            end
            mws_pkg::UPC_WAIT:
            begin
                cw.wait_div = 1'b1;
            end
            mws_pkg::UPC_LREM:
            begin
                cw.xsel = mws_pkg::X_HALFREM;
            end
            mws_pkg::UPC_LQ:
            begin
                cw.mq = 1'b1;
            end
            mws_pkg::UPC_LLAST:
            begin
                cw.dst  = mws_pkg::DST_LAST;
                cw.xsel = mws_pkg::X_DELAY;
            end
            mws_pkg::UPC_DQ:
            begin
                cw.mq = 1'b1;
            end
            mws_pkg::UPC_DPAUSE:
            begin
                cw.dst = mws_pkg::DST_PAUSE;
                cw.act = mws_pkg::ACT_ARM;
                cw.fin = 1'b1;
            end
            default:
            begin
                cw.fin = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/mws_divider.sv
// bit-serial restoring divider giving the remainder, one quotient bit per cycle
module mws_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mws_pkg::DIV_NUM_W-1:0] num,
    input  logic [mws_pkg::DIV_DEN_W-1:0] den,
    output logic                          busy,
    output logic [mws_pkg::DIV_DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(mws_pkg::DIV_NUM_W);

    logic                          busy_reg, busy_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [mws_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [mws_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [mws_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [mws_pkg::DIV_DEN_W:0]   trial;
    logic [mws_pkg::DIV_DEN_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, num_reg[mws_pkg::DIV_NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(mws_pkg::DIV_NUM_W - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[mws_pkg::DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
                rem_next = diff[mws_pkg::DIV_DEN_W-1:0];
            else
                rem_next = trial[mws_pkg::DIV_DEN_W-1:0];
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

>>> rtl/motor_waggle_sequencer.sv
// top level: microcoded two-motor waggle and shiver pattern sequencer
//
// input beats (s_*): s_tuser carries the kind of item (tick, start, stop, unused);
// a start beat carries the pattern in s_tdata. every input beat gives exactly
// one output beat (m_*) with both motor drives and the phase after the item.
// a step counter walks a short program in the control store; each item runs its
// own program, one item at a time. tick, stop and unused beats take one program
// step. a start beat runs eight program steps plus a wait step that holds while
// the remainder unit (one bit per cycle) works; for every item the result is
// registered when its last step executes, and the next item is taken after that.
// the result sits in the motor and phase registers, so the next item is taken
// while m_tvalid is still high; the program stalls on its last step if the
// previous beat has not been taken yet, and s_tready stays low meanwhile.
// reset puts the phase in done and both motors forward at full pulse width.
module motor_waggle_sequencer #(
    parameter int TICK_MS       = 10,
    parameter int PWM_PERIOD_US = 5080
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // mode
    input  logic [55:0] s_tdata,   // shiver, intensity, duration_ms, repeats, delay_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // left_forward, left_pulse_us, right_forward,
                                   // right_pulse_us, phase
);

    localparam logic [6:0]  TICK_V  = 7'(TICK_MS);
    localparam logic [15:0] PWM_V   = 16'(PWM_PERIOD_US);
    localparam int          TICK_LG = $clog2(TICK_MS);
    localparam int          SH      = 16 + TICK_LG;
    localparam int          RECIP_W = SH + 1;
    localparam int          PROD_W  = 16 + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

    mws_pkg::ctrl_t cw;
    logic           accept;
    logic           stall;
    logic           exec;
    logic           div_busy;
    logic [mws_pkg::DIV_DEN_W-1:0] div_rem;
    logic [mws_pkg::DIV_DEN_W-1:0] div_den;

    logic                    busy_reg, busy_next;
    logic [mws_pkg::UPC_W-1:0] upc_reg, upc_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              phase_reg, phase_next;
    logic                    swing_reg, swing_next;
    mws_pkg::motor_t         left_reg, left_next;
    mws_pkg::motor_t         right_reg, right_next;

    logic        in_shiver_reg;
    logic [7:0]  in_intensity_reg;
    logic [15:0] in_duration_reg;
    logic [7:0]  in_repeats_reg;
    logic [15:0] in_delay_reg;

    logic [6:0]  drive_reg, drive_next;
    logic [15:0] burst_len_reg, burst_len_next;
    logic [15:0] burst_left_reg, burst_left_next;
    logic [8:0]  half_period_reg, half_period_next;
    logic [8:0]  last_half_reg, last_half_next;
    logic signed [9:0] half_left_reg, half_left_next;
    logic [7:0]  repeats_left_reg, repeats_left_next;
    logic [15:0] pause_len_reg, pause_len_next;
    logic [15:0] pause_left_reg, pause_left_next;
    logic [15:0] x_reg, x_next;
    logic [15:0] q_reg, q_next;

    logic [7:0]        inv_int;
    logic [8:0]        period_raw;
    logic [6:0]        drive_raw;
    logic [PROD_W-1:0] prod;
    logic [22:0]       qt_full;
    logic [15:0]       qt;

    mws_ucode_rom u_rom (
        .upc (upc_reg),
        .cw  (cw)
    );

    mws_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exec && cw.div_go),
        .num   (burst_len_reg),
        .den   (div_den),
        .busy  (div_busy),
        .rem   (div_rem)
    );

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign stall    = (cw.fin && out_valid_reg && !m_tready) || (cw.wait_div && div_busy);
    assign exec     = busy_reg && !stall;

    // period and drive level from the intensity, constant divisions by 255
    always_comb
    begin
        inv_int   = 8'd255 - in_intensity_reg;
        drive_raw = 7'(mws_pkg::div255({2'b00, in_intensity_reg, 6'b000000})) + 7'd63;
        if (in_shiver_reg)
            period_raw = 9'(mws_pkg::div255(16'(inv_int) * 16'd50)) + 9'd50;
        else
            period_raw = 9'(inv_int) + 9'(mws_pkg::div255(16'(inv_int) * 16'd145))
                       + 9'd100;
    end

    // rounding down to whole ticks: reciprocal quotient, then quotient times tick
    assign prod    = PROD_W'(x_reg) * PROD_W'(RECIP);
    assign qt_full = 23'(q_reg) * 23'(TICK_V);
    assign qt      = qt_full[15:0];
    assign div_den = {qt[8:0], 1'b0};

    always_comb
    begin
        logic [1:0]        ph;
        logic [7:0]        rep;
        logic [15:0]       bl;
        logic signed [9:0] hl;
        logic              sw;
        logic [15:0]       pl;

        busy_next         = busy_reg;
        upc_next          = upc_reg;
        out_valid_next    = out_valid_reg;
        phase_next        = phase_reg;
        swing_next        = swing_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        drive_next        = drive_reg;
        burst_len_next    = burst_len_reg;
        burst_left_next   = burst_left_reg;
        half_period_next  = half_period_reg;
        last_half_next    = last_half_reg;
        half_left_next    = half_left_reg;
        repeats_left_next = repeats_left_reg;
        pause_len_next    = pause_len_reg;
        pause_left_next   = pause_left_reg;
        x_next            = x_reg;
        q_next            = q_reg;

        ph  = phase_reg;
        rep = repeats_left_reg;
        bl  = burst_left_reg;
        hl  = half_left_reg;
        sw  = swing_reg;
        pl  = pause_left_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            busy_next = 1'b1;
            unique case (s_tuser)
                mws_pkg::MODE_TICK:  upc_next = mws_pkg::UPC_TICK;
                mws_pkg::MODE_START: upc_next = mws_pkg::UPC_LOAD;
                mws_pkg::MODE_STOP:  upc_next = mws_pkg::UPC_STOP;
                mws_pkg::MODE_NONE:  upc_next = mws_pkg::UPC_NOP;
            endcase
        end

        if (exec)
        begin
            if (cw.fin)
            begin
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else
                upc_next = upc_reg + mws_pkg::UPC_W'(1);

            if (cw.mq)
                q_next = prod[SH +: 16];

            unique case (cw.xsel)
                mws_pkg::X_HOLD:    x_next = x_reg;
                mws_pkg::X_PERIOD:  x_next = 16'(period_raw);
                mws_pkg::X_HALFREM: x_next = (half_period_reg == 9'd0) ? 16'd0
                                           : 16'(div_rem[mws_pkg::DIV_DEN_W-1:1]);
                mws_pkg::X_DELAY:   x_next = in_delay_reg;
            endcase

            unique case (cw.dst)
                mws_pkg::DST_NONE:
                begin
                end
                mws_pkg::DST_HALF:
                begin
                    half_period_next = qt[8:0];
                    half_left_next   = $signed({1'b0, qt[8:0]});
                end
                mws_pkg::DST_LAST:
                begin
                    last_half_next = qt[8:0];
                end
                mws_pkg::DST_PAUSE:
                begin
                    pause_len_next  = qt;
                    pause_left_next = qt;
                end
            endcase

            unique case (cw.act)
                mws_pkg::ACT_LOAD:
                begin
                    drive_next        = drive_raw;
                    burst_len_next    = in_duration_reg;
                    burst_left_next   = in_duration_reg;
                    repeats_left_next = in_repeats_reg;
                    swing_next        = 1'b1;
                end
                mws_pkg::ACT_ARM:
                begin
                    phase_next = mws_pkg::PH_BEGIN;
                end
                mws_pkg::ACT_STOP:
                begin
                    left_next  = mws_pkg::drive_motor(1'b0, 7'd0, PWM_V);
                    right_next = mws_pkg::drive_motor(1'b0, 7'd0, PWM_V);
                    phase_next = mws_pkg::PH_DONE;
                end
                mws_pkg::ACT_TICK:
                begin
                    if (ph == mws_pkg::PH_BEGIN)
                    begin
                        if (rep != 8'd0)
                        begin
                            rep = rep - 8'd1;
                            ph  = mws_pkg::PH_OSC;
                            bl  = burst_len_reg;
                            hl  = $signed({1'b0, half_period_reg});
                            sw  = 1'b1;
                        end
                        else
                            ph = mws_pkg::PH_DONE;
                    end
                    if (ph == mws_pkg::PH_OSC)
                    begin
                        if (bl >= 16'(TICK_V))
                        begin
                            if (hl < $signed({3'b000, TICK_V}))
                            begin
                                if (bl > 16'({last_half_reg, 1'b0}))
                                    hl = $signed({1'b0, half_period_reg});
                                else
                                    hl = $signed({1'b0, last_half_reg});
                                sw = !sw;
                            end
                            left_next  = mws_pkg::drive_motor(!sw, drive_reg, PWM_V);
                            right_next = mws_pkg::drive_motor(sw, drive_reg, PWM_V);
                            bl = bl - 16'(TICK_V);
                            hl = hl - $signed({3'b000, TICK_V});
                        end
                        else
                        begin
                            left_next  = mws_pkg::drive_motor(1'b0, 7'd0, PWM_V);
                            right_next = mws_pkg::drive_motor(1'b0, 7'd0, PWM_V);
                            if (rep != 8'd0)
                            begin
                                ph = mws_pkg::PH_DELAY;
                                pl = pause_len_reg;
                            end
                            else
                                ph = mws_pkg::PH_DONE;
                        end
                    end
                    else if (ph == mws_pkg::PH_DELAY)
                    begin
                        if (pl >= 16'(TICK_V))
                            pl = pl - 16'(TICK_V);
                        else
                            ph = mws_pkg::PH_BEGIN;
                    end
                    phase_next        = ph;
                    repeats_left_next = rep;
                    burst_left_next   = bl;
                    half_left_next    = hl;
                    swing_next        = sw;
                    pause_left_next   = pl;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            upc_reg       <= mws_pkg::UPC_NOP;
            out_valid_reg <= 1'b0;
            phase_reg     <= mws_pkg::PH_DONE;
            swing_reg     <= 1'b1;
            left_reg      <= '{fwd: 1'b1, pulse: PWM_V[12:0]};
            right_reg     <= '{fwd: 1'b1, pulse: PWM_V[12:0]};
        end
        else
        begin
            busy_reg      <= busy_next;
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            swing_reg     <= swing_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_shiver_reg    <= s_tdata[0];
            in_intensity_reg <= s_tdata[8:1];
            in_duration_reg  <= s_tdata[24:9];
            in_repeats_reg   <= s_tdata[32:25];
            in_delay_reg     <= s_tdata[48:33];
        end
        drive_reg        <= drive_next;
        burst_len_reg    <= burst_len_next;
        burst_left_reg   <= burst_left_next;
        half_period_reg  <= half_period_next;
        last_half_reg    <= last_half_next;
        half_left_reg    <= half_left_next;
        repeats_left_reg <= repeats_left_next;
        pause_len_reg    <= pause_len_next;
        pause_left_reg   <= pause_left_next;
        x_reg            <= x_next;
        q_reg            <= q_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, phase_reg, right_reg.pulse, right_reg.fwd,
                       left_reg.pulse, left_reg.fwd};

endmodule

>>> rtl/mws_checker.sv
// port-level checks of the motor waggle sequencer, bound to the top level
module mws_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // a new result only comes out of an item in work
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without an item in work");

    // the motors never both run in reverse
    a_opposed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] || m_tdata[14]))
        else $error("both motors reversed");

endmodule

bind motor_waggle_sequencer mws_checker u_mws_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/motor_waggle_sequencer_test.sv
`timescale 1ns / 1ps
// testbench for motor_waggle_sequencer: tick, start and stop beats checked against a predictor
module motor_waggle_sequencer_test;

    localparam int TICK        = 10;
    localparam int PWM         = 5080;
    localparam int BEAT_TARGET = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        bit        lf;
        bit [12:0] lp;
        bit        rf;
        bit [12:0] rp;
        bit [1:0]  ph;
    } drive_word_t;

    class waggle_scoreboard;
        bit [1:0]    phase;
        int          level;
        int          burst_len;
        int          burst_rem;
        int          half_per;
        int          last_half;
        int          half_rem;
        int          reps_left;
        int          pause_len;
        int          pause_rem;
        int          dir;
        drive_word_t now;
        drive_word_t pending[$];
        int          errors;

        function new();
            phase     = mws_pkg::PH_DONE;
            level     = 0;
            burst_len = 0;
            burst_rem = 0;
            half_per  = 0;
            last_half = 0;
            half_rem  = 0;
            reps_left = 0;
            pause_len = 0;
            pause_rem = 0;
            dir       = 1;
            errors    = 0;
            set_drive(0);
        endfunction

        function void motor(int s, output bit fwd, output bit [12:0] pulse);
            int p;
            if (s > 127)
                s = 127;
            if (s < -127)
                s = -127;
            if (s == 0)
            begin
                fwd   = 1'b1;
                pulse = 13'(PWM);
            end
            else if (s > 0)
            begin
                p = PWM - 40 * s;
                if (p < 0)
                    p = 0;
                fwd   = 1'b1;
                pulse = 13'(p);
            end
            else
            begin
                fwd   = 1'b0;
                pulse = 13'(-40 * s);
            end
        endfunction

        function void set_drive(int s);
            motor(s, now.lf, now.lp);
            motor(-s, now.rf, now.rp);
        endfunction

        function void advance_tick();
            if (phase == mws_pkg::PH_BEGIN)
            begin
                if (reps_left > 0)
                begin
                    reps_left--;
                    phase     = mws_pkg::PH_OSC;
                    burst_rem = burst_len;
                    half_rem  = half_per;
                    dir       = 1;
                end
                else
                begin
                    phase = mws_pkg::PH_DONE;
                    return;
                end
            end
            if (phase == mws_pkg::PH_OSC)
            begin
                if (burst_rem >= TICK)
                begin
                    if (half_rem < TICK)
                    begin
                        half_rem = (burst_rem > 2 * last_half) ? half_per : last_half;
                        dir      = -dir;
                    end
                    set_drive(dir * level);
                    burst_rem -= TICK;
                    half_rem  -= TICK;
                end
                else if (reps_left > 0)
                begin
                    phase = mws_pkg::PH_DELAY;
                    set_drive(0);
                    pause_rem = pause_len;
                end
                else
                begin
                    phase = mws_pkg::PH_DONE;
                    set_drive(0);
                end
            end
            else if (phase == mws_pkg::PH_DELAY)
            begin
                if (pause_rem >= TICK)
                    pause_rem -= TICK;
                else
                    phase = mws_pkg::PH_BEGIN;
            end
        endfunction

        function void load_pattern(bit shv, int inten, int dur, int reps, int dly);
            int p;
            level = inten * 64 / 255 + 63;
            p = shv ? 50 * (255 - inten) / 255 + 50 : 400 * (255 - inten) / 255 + 100;
            p -= p % TICK;
            half_per  = p;
            burst_len = dur;
            burst_rem = dur;
            last_half = (p != 0) ? (dur % (2 * p)) / 2 : 0;
            last_half -= last_half % TICK;
            half_rem  = p;
            reps_left = reps;
            pause_len = dly - dly % TICK;
            pause_rem = pause_len;
            dir       = 1;
            phase     = mws_pkg::PH_BEGIN;
        endfunction

        function void note_beat(bit [1:0] mode, bit [55:0] data);
            drive_word_t w;
            case (mode)
                mws_pkg::MODE_TICK:  advance_tick();
                mws_pkg::MODE_START:
                begin
                    load_pattern(data[0], int'(data[8:1]), int'(data[24:9]),
                                 int'(data[32:25]), int'(data[48:33]));
                end
                mws_pkg::MODE_STOP:
                begin
                    set_drive(0);
                    phase = mws_pkg::PH_DONE;
                end
                default: ;
            endcase
            w    = now;
            w.ph = phase;
            pending.push_back(w);
        endfunction

        function void check_beat(bit [31:0] d);
            drive_word_t e;
            drive_word_t a;
            a.lf = d[0];
            a.lp = d[13:1];
            a.rf = d[14];
            a.rp = d[27:15];
            a.ph = d[29:28];
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat %h", d);
                return;
            end
            e = pending.pop_front();
            if (a.lf != e.lf || a.lp != e.lp || a.rf != e.rf || a.rp != e.rp
                || a.ph != e.ph)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch at %0t: expected lf %0d lp %0d rf %0d rp %0d ",
                              "phase %0d, got lf %0d lp %0d rf %0d rp %0d phase %0d"},
                             $realtime, e.lf, e.lp, e.rf, e.rp, e.ph,
                             a.lf, a.lp, a.rf, a.rp, a.ph);
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser  = mws_pkg::MODE_TICK;
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    waggle_scoreboard sb;
    int beats_sent    = 0;
    int burst_items   = 0;
    int results_seen  = 0;

    always #2 clk = ~clk;

    motor_waggle_sequencer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic logic [55:0] pack_start(int shv, int inten, int dur, int reps, int dly);
        return {7'd0, 16'(dly), 8'(reps), 16'(dur), 8'(inten), 1'(shv)};
    endfunction

    function automatic logic [55:0] noise_data();
        return 56'({$urandom(), $urandom()});
    endfunction

    // offer one beat, opening a new burst after a random gap when the last one ran out
    task automatic send(input logic [1:0] mode, input logic [55:0] data);
        int gap;
        if (burst_items == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_items = $urandom_range(1, 24);
        end
        burst_items--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(mode, data);
        if (mode != mws_pkg::MODE_NONE)
            beats_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_beat(m_tdata);
            results_seen++;
        end
    end

    // receiver stall pattern, with one long hold-off so the block backs up
    initial
    begin
        int  kind;
        int  seg_left;
        int  hold;
        bit  held;
        kind     = 0;
        seg_left = 0;
        hold     = 0;
        held     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 120)
            begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    kind     = $urandom_range(0, 3);
                    seg_left = $urandom_range(4, 60);
                end
                seg_left--;
                case (kind)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (seg_left % 4) != 0;
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int shv;
        int inten;
        int dur;
        int reps;
        int dly;
        int ticks;
        int tick_cap;
        int pick;
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle tick, unused mode, stop, extremes, zero repeats
        send(mws_pkg::MODE_TICK, '0);
        send(mws_pkg::MODE_NONE, {56{1'b1}});
        send(mws_pkg::MODE_STOP, '0);
        send(mws_pkg::MODE_START, pack_start(1, 255, 65535, 255, 65535));
        repeat (3) send(mws_pkg::MODE_TICK, '0);
        send(mws_pkg::MODE_STOP, '0);
        send(mws_pkg::MODE_START, pack_start(0, 0, 0, 1, 0));
        repeat (2) send(mws_pkg::MODE_TICK, {56{1'b1}});
        send(mws_pkg::MODE_START, pack_start(0, 255, 45, 2, 15));
        repeat (9) send(mws_pkg::MODE_TICK, '0);
        send(mws_pkg::MODE_START, pack_start(0, 128, 100, 0, 0));
        send(mws_pkg::MODE_TICK, '0);

        // random patterns run through their phases, with noise and early stops
        while (beats_sent < BEAT_TARGET)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                shv   = $urandom_range(0, 1);
                inten = $urandom_range(0, 255);
                dur   = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 300)
                                                    : $urandom_range(0, 65535);
                reps  = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3)
                                                    : $urandom_range(0, 255);
                dly   = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, 65535);
                send(mws_pkg::MODE_START, pack_start(shv, inten, dur, reps, dly));
                ticks    = 0;
                tick_cap = $urandom_range(10, 60);
                while (sb.phase != mws_pkg::PH_DONE && ticks < tick_cap)
                begin
                    pick = $urandom_range(0, 59);
                    if (pick == 0)
                        send(mws_pkg::MODE_STOP, noise_data());
                    else if (pick < 3)
                        send(mws_pkg::MODE_NONE, noise_data());
                    else
                    begin
                        send(mws_pkg::MODE_TICK, noise_data());
                        ticks++;
                    end
                end
                if (sb.phase != mws_pkg::PH_DONE && $urandom_range(0, 1) == 0)
                    send(mws_pkg::MODE_STOP, noise_data());
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send(2'($urandom_range(0, 3)), noise_data());
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/mws_pkg.sv
rtl/mws_ucode_rom.sv
rtl/mws_divider.sv
rtl/motor_waggle_sequencer.sv
rtl/mws_checker.sv
tb/sv/motor_waggle_sequencer_test.sv
